[hw/rtl/bda_pkg.sv]
// shared types and constants for the binary to decimal ascii converter
// used by bda_ctrl, bda_datapath and binary_to_decimal_ascii
`timescale 1ns / 1ps

package bda_pkg;

  localparam int VALUE_W = 32;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 6;
  localparam int DATA_IN_W  = 32;
  localparam int DATA_OUT_W = 8;

  // ascii '0' reduced to the six-bit character field
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // divide by ten as multiply by ceil(2^35 / 10) and shift right by 35
  localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCCCCCD;
  localparam int DIV10_SHIFT = 35;

  // a 32-bit value never has more than ten decimal digits
  localparam int MAX_VALUE_DIGITS = 10;

  // controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;   // capture a new value
    logic step;   // one divide-by-ten step
    logic emit;   // move one digit into the output register
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;   // current divide step is the final one
    logic out_free;   // output register can take a character
    logic emit_last;  // next character out is the least significant
  } dp_status_t;

endpackage

[hw/rtl/bda_ctrl.sv]
// controller state machine for the binary to decimal ascii converter
// depends on bda_pkg for the state, command and status types
`timescale 1ns / 1ps

module bda_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bda_pkg::dp_status_t status,
  output bda_pkg::ctrl_cmd_t  cmd
);

  import bda_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no request is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/bda_datapath.sv]
// datapath: divide-by-ten unit, digit stack and output register
// depends on bda_pkg for widths, constants and the command and status types
`timescale 1ns / 1ps

module bda_datapath #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bda_pkg::VALUE_W-1:0]  value,
  input  bda_pkg::ctrl_cmd_t           cmd,
  output bda_pkg::dp_status_t          status,
  output logic [bda_pkg::CHAR_W-1:0]   digit_char,
  output logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready
);

  import bda_pkg::*;

  localparam int DEPTH = (MAX_DIGITS < MAX_VALUE_DIGITS) ? MAX_DIGITS : MAX_VALUE_DIGITS;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VALUE_W-1:0]   work;
  logic [CW-1:0]        cnt;
  logic [IW-1:0]        rd_idx;
  logic [DIGIT_W-1:0]   digits [DEPTH];

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   quot_x10;
  logic [VALUE_W-1:0]   rem_full;
  logic [DIGIT_W-1:0]   rem;
  logic                 emit_fire;

  // quotient and remainder of the working value by ten
  assign prod     = (2*VALUE_W)'(work) * (2*VALUE_W)'(DIV10_RECIP);
  assign quot     = VALUE_W'(prod[2*VALUE_W-1:DIV10_SHIFT]);
  assign quot_x10 = {quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0};
  assign rem_full = work - quot_x10;
  assign rem      = rem_full[DIGIT_W-1:0];

  // status back to the controller
  assign status.div_last  = (quot == '0) || (cnt == CW'(DEPTH - 1));
  assign status.out_free  = !out_valid || out_ready;
  assign status.emit_last = (rd_idx == '0);

  assign emit_fire = cmd.emit && status.out_free;

  // working value, digit count and digit stack
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= value;
      cnt  <= '0;
    end else if (cmd.step) begin
      work                 <= quot;
      cnt                  <= cnt + 1'b1;
      digits[cnt[IW-1:0]]  <= rem;
      rd_idx               <= cnt[IW-1:0];
    end else if (emit_fire) begin
      rd_idx <= rd_idx - 1'b1;
    end
  end

  // output character payload
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      digit_char <= ASCII_ZERO + CHAR_W'(digits[rd_idx]);
      last       <= (rd_idx == '0);
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hw/rtl/binary_to_decimal_ascii.sv]
// top level of the binary to decimal ascii converter
// depends on bda_pkg, bda_ctrl and bda_datapath
`timescale 1ns / 1ps

// Converts one unsigned 32-bit value per request into its decimal ASCII
// digits, most significant first, no leading zeros, with tlast on the final
// digit; zero gives a single '0'. Values with more than MAX_DIGITS digits
// give only their MAX_DIGITS low digits. Each value is accepted, then runs
// through the one-digit-per-cycle divide-by-ten unit (a reciprocal
// multiply), and its digit stack is then streamed out through the output
// register, which waits on m_tready. The next
// value is accepted while the last digit still waits in the output register.

module binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bda_pkg::DATA_IN_W-1:0]     s_tdata,   // [31:0] value
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bda_pkg::DATA_OUT_W-1:0]    m_tdata,   // [5:0] digit_char, [7:6] zero
  output logic                              m_tlast
);

  import bda_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic [CHAR_W-1:0]  digit_char;

  // sequencing
  bda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, digit storage and output register
  bda_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .value      (s_tdata[VALUE_W-1:0]),
    .cmd        (cmd),
    .status     (status),
    .digit_char (digit_char),
    .last       (m_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready)
  );

  // pack the character into the byte-wide data bus
  assign m_tdata = {{(DATA_OUT_W - CHAR_W){1'b0}}, digit_char};

endmodule

[tb/binary_to_decimal_ascii_tb.sv]
// self-checking testbench for the binary to decimal ascii converter
// depends on bda_pkg and binary_to_decimal_ascii; drives values, checks every digit
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;

  import bda_pkg::*;

  localparam int MAX_DIGITS = 10;
  localparam int DRAIN_CYCLES = 2 * MAX_VALUE_DIGITS + 10;

  typedef enum logic {
    RX_ALWAYS,
    RX_PATTERN
  } rx_mode_t;

  // one expected output character
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_rec_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [DATA_IN_W-1:0]   s_tdata = '0;    // [31:0] value
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [DATA_OUT_W-1:0]  m_tdata;         // [5:0] digit_char, [7:6] zero
  logic                   m_tlast;

  char_rec_t pending_chars[$];
  int        mismatches = 0;
  int        values_sent = 0;
  int        chars_seen = 0;
  int        gap_max = 0;
  int        burst_left = 0;
  int        hold_cycles = 0;
  rx_mode_t  rx_mode = RX_ALWAYS;
  logic [15:0] stall_pat = 16'hA5C3;
  int        pat_age = 0;

  // values at the edges of the digit count and of the 32-bit range
  localparam logic [31:0] EDGE_VALUES [18] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd65535,
    32'd999999999, 32'd1000000000, 32'd1000000001, 32'd1234567890,
    32'd2147483647, 32'd2147483648, 32'd4000000000, 32'd4294967290,
    32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFF
  };

  binary_to_decimal_ascii #(
    .MAX_DIGITS(MAX_DIGITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected digit characters of one value, most significant first
  function automatic void decimal_chars(input logic [31:0] v);
    logic [3:0]  digs [0:19];
    logic [31:0] r;
    int          n;
    char_rec_t   c;
    r = v;
    n = 0;
    if (r == 32'd0) begin
      c.ch = ASCII_ZERO;
      c.last = 1'b1;
      pending_chars.push_back(c);
      return;
    end
    // low digits first, dropping any beyond the digit limit
    while (r != 32'd0 && n < MAX_DIGITS && n < 20) begin
      digs[n] = 4'(r % 32'd10);
      r = r / 32'd10;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.ch = ASCII_ZERO + digs[k];
      c.last = (k == 0);
      pending_chars.push_back(c);
    end
  endfunction

  // mix of full-range, short, tiny and power-of-ten neighbor values
  function automatic logic [31:0] random_value();
    logic [31:0] p;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 99);
      default: begin
        p = 1;
        repeat ($urandom_range(1, 9)) p = p * 10;
        return p - 1 + $urandom_range(0, 2);
      end
    endcase
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // send one request, idling in bursts, and record its digits once accepted
  task automatic send_value(input logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decimal_chars(v);
    values_sent++;
    burst_left--;
  endtask

  // drop valid and set up sender idling and receiver behavior for a phase
  task automatic start_phase(input rx_mode_t mode, input int gmax, input int hold);
    s_tvalid <= 1'b0;
    @(negedge clk);
    rx_mode = mode;
    gap_max = gmax;
    burst_left = 0;
    hold_cycles = hold;
    @(posedge clk);
  endtask

  task automatic test_edge_values();
    start_phase(RX_PATTERN, 3, 0);
    foreach (EDGE_VALUES[i]) send_value(EDGE_VALUES[i]);
  endtask

  task automatic test_random_values(input int count);
    start_phase(RX_PATTERN, 12, 0);
    repeat (count) send_value(random_value());
  endtask

  task automatic test_back_to_back(input int count);
    start_phase(RX_ALWAYS, 0, 0);
    repeat (count) send_value(random_value());
  endtask

  // receiver holds off long while the sender keeps offering values
  task automatic test_output_hold(input int count);
    start_phase(RX_PATTERN, 0, 300);
    repeat (count) send_value($urandom);
  endtask

  task automatic test_mixed_idle(input int count);
    start_phase(RX_PATTERN, 25, 0);
    repeat (count) send_value(random_value());
  endtask

  // receiver: long hold-off on request, else always ready or a rotating pattern
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_mode == RX_ALWAYS) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= stall_pat[0];
      if (pat_age == 31) begin
        stall_pat <= 16'($urandom) | 16'h0101;
        pat_age <= 0;
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
        pat_age <= pat_age + 1;
      end
    end
  end

  // compare each accepted character with the oldest expected one
  always @(posedge clk) begin
    char_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        note_mismatch("unexpected character", -1, m_tdata);
      end else begin
        want = pending_chars.pop_front();
        if (m_tdata[CHAR_W-1:0] !== want.ch)
          note_mismatch("digit_char", want.ch, m_tdata[CHAR_W-1:0]);
        if (m_tdata[DATA_OUT_W-1:CHAR_W] !== '0)
          note_mismatch("tdata padding", 0, m_tdata[DATA_OUT_W-1:CHAR_W]);
        if (m_tlast !== want.last)
          note_mismatch("last", want.last, m_tlast);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_values();
    test_random_values(150);
    test_back_to_back(100);
    test_output_hold(20);
    test_mixed_idle(130);

    // let every expected digit come out, then watch for strays
    start_phase(RX_ALWAYS, 0, 0);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0)
      note_mismatch("characters never produced", pending_chars.size(), 0);

    $display("covered %0d values (range edges, power-of-ten neighbors, random widths)",
             values_sent);
    $display("checked %0d digit characters under input gaps, output stalls and a long hold-off",
             chars_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d characters still expected", pending_chars.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
